/* hw/rtl/nics_pkg.sv */
// Shared types, widths and constants for the normal inverse-CDF sampler.
package nics_pkg;

  localparam int unsigned SampleBitsDef = 31;

  // Fixed-point widths along the datapath
  localparam int unsigned LogRounds = 24;
  localparam int unsigned T2W       = 30;  // t^2, Q.24
  localparam int unsigned TW        = 27;  // t, Q.24
  localparam int unsigned SqrtSteps = 27;
  localparam int unsigned NumW      = 28;
  localparam int unsigned DenW      = 29;
  localparam int unsigned RatW      = 28;
  localparam int unsigned DivSteps  = 28;
  localparam int unsigned MagW      = 28;
  localparam int unsigned ProdW     = 36;

  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  localparam logic [24:0] OneQ24 = 25'd16777216;
  localparam logic [25:0] C0Q24  = 26'd42203372;
  localparam logic [23:0] C1Q24  = 24'd13469638;
  localparam logic [17:0] C2Q24  = 18'd173275;
  localparam logic [24:0] D1Q24  = 25'd24038194;
  localparam logic [21:0] D2Q24  = 22'd3175407;
  localparam logic [14:0] D3Q24  = 15'd21945;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegMean = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStd  = 2'd1;

  localparam logic [30:0] StdReset = 31'd65536;

  typedef struct packed {
    logic [30:0] uniform_sample;
    logic        batch_end;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] normal_sample;
    logic               batch_end_out;
  } out_word_t;

  // Per-word flags that ride alongside the datapath
  typedef struct packed {
    logic mid;   // exact midpoint, result is the mean
    logic neg;   // lower half of the distribution
    logic last;  // batch end mark
  } side_t;

endpackage

/* hw/rtl/nics_log2.sv */
// Pipelined -log2 by square-and-compare, followed by the scale to t^2.
module nics_log2 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  nics_pkg::side_t            side_i,
  input  logic [31:0]                x_i,
  input  logic [5:0]                 ip_i,
  output logic                       vld_o,
  output nics_pkg::side_t            side_o,
  output logic [nics_pkg::T2W-1:0]   t2_o
);
  localparam int unsigned N = nics_pkg::LogRounds;

  logic            vld_q  [1:N];
  nics_pkg::side_t side_q [1:N];
  logic [31:0]     x_q    [1:N];
  logic [N-1:0]    frac_q [1:N];
  logic [5:0]      ip_q   [1:N];

  for (genvar k = 0; k < N; k++) begin : g_round
    logic            v_in;
    nics_pkg::side_t s_in;
    logic [31:0]     x_in;
    logic [N-1:0]    f_in;
    logic [5:0]      i_in;
    logic [63:0]     sq;
    logic [32:0]     sh;

    if (k == 0) begin : g_first
      assign v_in = vld_i;
      assign s_in = side_i;
      assign x_in = x_i;
      assign f_in = '0;
      assign i_in = ip_i;
    end else begin : g_next
      assign v_in = vld_q[k];
      assign s_in = side_q[k];
      assign x_in = x_q[k];
      assign f_in = frac_q[k];
      assign i_in = ip_q[k];
    end

    assign sq = 64'(x_in) * 64'(x_in);
    assign sh = sq[63:31];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= s_in;
        ip_q[k+1]   <= i_in;
        if (sh[32]) begin
          x_q[k+1]    <= sh[32:1];
          frac_q[k+1] <= {f_in[N-2:0], 1'b1};
        end else begin
          x_q[k+1]    <= sh[31:0];
          frac_q[k+1] <= {f_in[N-2:0], 1'b0};
        end
      end
    end
  end

  // -log2 q in Q6.24, then t^2 = 2 ln2 * (-log2 q)
  logic [29:0] nl;
  logic [61:0] t2_full;
  assign nl      = {ip_q[N], 24'b0} - 30'(frac_q[N]);
  assign t2_full = 62'(nl) * 62'(nics_pkg::Ln2Q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_q[N];
      t2_o   <= t2_full[60:31];
    end
  end

endmodule

/* hw/rtl/nics_sqrt.sv */
// Digit-by-digit integer square root, one result bit per stage.
module nics_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  nics_pkg::side_t          side_i,
  input  logic [nics_pkg::T2W-1:0] t2_i,
  output logic                     vld_o,
  output nics_pkg::side_t          side_o,
  output logic [nics_pkg::TW-1:0]  t_o
);
  localparam int unsigned N  = nics_pkg::SqrtSteps;
  localparam int unsigned VW = nics_pkg::T2W + 24;

  logic                     vld_q  [1:N];
  nics_pkg::side_t          side_q [1:N];
  logic [nics_pkg::T2W-1:0] t2_q   [1:N];
  logic [29:0]              rem_q  [1:N];
  logic [N-1:0]             root_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                     v_in;
    nics_pkg::side_t          s_in;
    logic [nics_pkg::T2W-1:0] a_in;
    logic [29:0]              r_in;
    logic [N-1:0]             o_in;
    logic [VW-1:0]            v_word;
    logic [29:0]              rem_sh;
    logic [29:0]              trial;
    logic                     ge;

    if (k == 0) begin : g_first
      assign v_in = vld_i;
      assign s_in = side_i;
      assign a_in = t2_i;
      assign r_in = '0;
      assign o_in = '0;
    end else begin : g_next
      assign v_in = vld_q[k];
      assign s_in = side_q[k];
      assign a_in = t2_q[k];
      assign r_in = rem_q[k];
      assign o_in = root_q[k];
    end

    assign v_word = {a_in, 24'b0};
    assign rem_sh = {r_in[27:0], v_word[VW-1-2*k -: 2]};
    assign trial  = {1'b0, o_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= s_in;
        t2_q[k+1]   <= a_in;
        rem_q[k+1]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k+1] <= {o_in[N-2:0], ge};
      end
    end
  end

  assign vld_o  = vld_q[N];
  assign side_o = side_q[N];
  assign t_o    = root_q[N];

endmodule

/* hw/rtl/nics_poly.sv */
// Numerator and denominator polynomials in t, four stages.
module nics_poly (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  nics_pkg::side_t           side_i,
  input  logic [nics_pkg::TW-1:0]   t_i,
  output logic                      vld_o,
  output nics_pkg::side_t           side_o,
  output logic [nics_pkg::TW-1:0]   t_o,
  output logic [nics_pkg::NumW-1:0] num_o,
  output logic [nics_pkg::DenW-1:0] den_o
);
  localparam int unsigned TW = nics_pkg::TW;

  logic [3:0]      vld_q;
  nics_pkg::side_t side_q [4];

  // stage 1
  logic [TW-1:0] p1_t_q;
  logic [29:0]   p1_tt_q;
  logic [26:0]   p1_c1t_q;
  logic [27:0]   p1_d1t_q;
  // stage 2
  logic [TW-1:0] p2_t_q;
  logic [32:0]   p2_ttt_q;
  logic [26:0]   p2_c1t_q;
  logic [27:0]   p2_d1t_q;
  logic [23:0]   p2_c2tt_q;
  logic [27:0]   p2_d2tt_q;
  // stage 3
  logic [TW-1:0]              p3_t_q;
  logic [23:0]                p3_d3_q;
  logic [nics_pkg::NumW-1:0]  p3_num_q;
  logic [nics_pkg::DenW-1:0]  p3_den_q;

  logic [63:0] m_tt, m_c1, m_d1, m_ttt, m_c2, m_d2, m_d3;
  assign m_tt  = 64'(t_i) * 64'(t_i);
  assign m_c1  = 64'(nics_pkg::C1Q24) * 64'(t_i);
  assign m_d1  = 64'(nics_pkg::D1Q24) * 64'(t_i);
  assign m_ttt = 64'(p1_tt_q) * 64'(p1_t_q);
  assign m_c2  = 64'(nics_pkg::C2Q24) * 64'(p1_tt_q);
  assign m_d2  = 64'(nics_pkg::D2Q24) * 64'(p1_tt_q);
  assign m_d3  = 64'(nics_pkg::D3Q24) * 64'(p2_ttt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
      side_q[3] <= side_q[2];

      p1_t_q   <= t_i;
      p1_tt_q  <= m_tt[53:24];
      p1_c1t_q <= m_c1[50:24];
      p1_d1t_q <= m_d1[51:24];

      p2_t_q    <= p1_t_q;
      p2_ttt_q  <= m_ttt[56:24];
      p2_c1t_q  <= p1_c1t_q;
      p2_d1t_q  <= p1_d1t_q;
      p2_c2tt_q <= m_c2[47:24];
      p2_d2tt_q <= m_d2[51:24];

      p3_t_q   <= p2_t_q;
      p3_d3_q  <= m_d3[47:24];
      p3_num_q <= 28'(nics_pkg::C0Q24) + 28'(p2_c1t_q) + 28'(p2_c2tt_q);
      p3_den_q <= 29'(nics_pkg::OneQ24) + 29'(p2_d1t_q) + 29'(p2_d2tt_q);

      t_o   <= p3_t_q;
      num_o <= p3_num_q;
      den_o <= p3_den_q + 29'(p3_d3_q);
    end
  end

  assign vld_o  = vld_q[3];
  assign side_o = side_q[3];

endmodule

/* hw/rtl/nics_div.sv */
// Restoring divider for (num << 24) / den, one quotient bit per stage.
module nics_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  nics_pkg::side_t           side_i,
  input  logic [nics_pkg::TW-1:0]   t_i,
  input  logic [nics_pkg::NumW-1:0] num_i,
  input  logic [nics_pkg::DenW-1:0] den_i,
  output logic                      vld_o,
  output nics_pkg::side_t           side_o,
  output logic [nics_pkg::TW-1:0]   t_o,
  output logic [nics_pkg::RatW-1:0] ratio_o
);
  localparam int unsigned N  = nics_pkg::DivSteps;
  localparam int unsigned DW = nics_pkg::DenW;

  // Quotient stays below 2^28, so the upper dividend bits seed the remainder.
  logic                      vld_q  [1:N];
  nics_pkg::side_t           side_q [1:N];
  logic [nics_pkg::TW-1:0]   t_q    [1:N];
  logic [3:0]                lo_q   [1:N];
  logic [DW-1:0]             den_q  [1:N];
  logic [DW-1:0]             rem_q  [1:N];
  logic [N-1:0]              quo_q  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                    v_in;
    nics_pkg::side_t         s_in;
    logic [nics_pkg::TW-1:0] t_in;
    logic [3:0]              l_in;
    logic [DW-1:0]           d_in;
    logic [DW-1:0]           r_in;
    logic [N-1:0]            q_in;
    logic                    nb;
    logic [DW:0]             rem_sh;
    logic                    ge;

    if (k == 0) begin : g_first
      assign v_in = vld_i;
      assign s_in = side_i;
      assign t_in = t_i;
      assign l_in = num_i[3:0];
      assign d_in = den_i;
      assign r_in = DW'(num_i[nics_pkg::NumW-1:4]);
      assign q_in = '0;
    end else begin : g_next
      assign v_in = vld_q[k];
      assign s_in = side_q[k];
      assign t_in = t_q[k];
      assign l_in = lo_q[k];
      assign d_in = den_q[k];
      assign r_in = rem_q[k];
      assign q_in = quo_q[k];
    end

    // dividend bit 27-k of {num[3:0], 24'b0}
    if (k < 4) begin : g_hi
      assign nb = l_in[3-k];
    end else begin : g_lo
      assign nb = 1'b0;
    end

    assign rem_sh = {r_in, nb};
    assign ge     = rem_sh >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= s_in;
        t_q[k+1]    <= t_in;
        lo_q[k+1]   <= l_in;
        den_q[k+1]  <= d_in;
        rem_q[k+1]  <= ge ? DW'(rem_sh - {1'b0, d_in}) : DW'(rem_sh);
        quo_q[k+1]  <= {q_in[N-2:0], ge};
      end
    end
  end

  assign vld_o   = vld_q[N];
  assign side_o  = side_q[N];
  assign t_o     = t_q[N];
  assign ratio_o = quo_q[N];

endmodule

/* hw/rtl/normal_inverse_cdf_sampler_core.sv */
// Throughput: one word per cycle; the whole pipeline advances on one enable,
//   held only while the output register is full and not taken.
// Stage mix: 2 prep, 25 log2, 27 sqrt, 4 polynomial, 28 divide, 3 output.
// Reset: async active low clears all valid bits, mean to 0 and sd to 1.0.
module normal_inverse_cdf_sampler_core #(
  parameter int unsigned SAMPLE_BITS = nics_pkg::SampleBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  nics_pkg::in_word_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output nics_pkg::out_word_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [nics_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);

  localparam logic [SAMPLE_BITS-1:0] Half = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [31:0] mean_q;
  logic [30:0]        std_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= nics_pkg::StdReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nics_pkg::RegMean: mean_q <= cfg_data_i;
        nics_pkg::RegStd:  std_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Global pipeline enable: everything moves unless the output word is stuck.
  logic pipe_en;
  assign pipe_en    = out_ready_i || !out_valid_o;
  assign in_ready_o = pipe_en;

  // ---------------------------------------------------------------------
  // Prep stage A: fold u onto the lower tail, find the leading one of q.
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] u_w, q_w;
  logic [31:0]            q32_w;
  logic [4:0]             msb_w;
  nics_pkg::side_t        side_w;

  always_comb begin
    u_w = SAMPLE_BITS'({1'b0, in_data_i.uniform_sample});
    if (u_w == '0) begin
      u_w = SAMPLE_BITS'(1);  // zero clamps to one LSB
    end
    side_w.mid  = (u_w == Half);
    side_w.neg  = (u_w < Half);
    side_w.last = in_data_i.batch_end;
    q_w   = side_w.neg ? u_w : ('0 - u_w);
    q32_w = 32'(q_w) << (32 - SAMPLE_BITS);
    msb_w = '0;
    for (int i = 0; i < 32; i++) begin
      if (q32_w[i]) msb_w = 5'(i);
    end
  end

  logic            a_vld_q;
  nics_pkg::side_t a_side_q;
  logic [31:0]     a_q32_q;
  logic [4:0]      a_msb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (pipe_en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_side_q <= side_w;
      a_q32_q  <= q32_w;
      a_msb_q  <= msb_w;
    end
  end

  // Prep stage B: normalize mantissa to [1,2) and note the integer log part.
  logic            b_vld_q;
  nics_pkg::side_t b_side_q;
  logic [31:0]     b_x_q;
  logic [5:0]      b_ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (pipe_en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      b_side_q <= a_side_q;
      b_x_q    <= a_q32_q << (5'd31 - a_msb_q);
      b_ip_q   <= 6'd32 - {1'b0, a_msb_q};
    end
  end

  // ---------------------------------------------------------------------
  // t^2 = -2 ln q, t = sqrt(t^2), rational correction P(t)/Q(t)
  // ---------------------------------------------------------------------
  logic                           lg_vld;
  nics_pkg::side_t                lg_side;
  logic [nics_pkg::T2W-1:0]       lg_t2;

  nics_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (b_vld_q),
    .side_i (b_side_q),
    .x_i    (b_x_q),
    .ip_i   (b_ip_q),
    .vld_o  (lg_vld),
    .side_o (lg_side),
    .t2_o   (lg_t2)
  );

  logic                    sq_vld;
  nics_pkg::side_t         sq_side;
  logic [nics_pkg::TW-1:0] sq_t;

  nics_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (lg_vld),
    .side_i (lg_side),
    .t2_i   (lg_t2),
    .vld_o  (sq_vld),
    .side_o (sq_side),
    .t_o    (sq_t)
  );

  logic                      pl_vld;
  nics_pkg::side_t           pl_side;
  logic [nics_pkg::TW-1:0]   pl_t;
  logic [nics_pkg::NumW-1:0] pl_num;
  logic [nics_pkg::DenW-1:0] pl_den;

  nics_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (sq_vld),
    .side_i (sq_side),
    .t_i    (sq_t),
    .vld_o  (pl_vld),
    .side_o (pl_side),
    .t_o    (pl_t),
    .num_o  (pl_num),
    .den_o  (pl_den)
  );

  logic                      dv_vld;
  nics_pkg::side_t           dv_side;
  logic [nics_pkg::TW-1:0]   dv_t;
  logic [nics_pkg::RatW-1:0] dv_ratio;

  nics_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .vld_i   (pl_vld),
    .side_i  (pl_side),
    .t_i     (pl_t),
    .num_i   (pl_num),
    .den_i   (pl_den),
    .vld_o   (dv_vld),
    .side_o  (dv_side),
    .t_o     (dv_t),
    .ratio_o (dv_ratio)
  );

  // ---------------------------------------------------------------------
  // Output stages: |z|, scale by sd with rounding, sign, add mean, saturate
  // ---------------------------------------------------------------------
  logic [28:0]               z_w;
  assign z_w = {2'b0, dv_t} - {1'b0, dv_ratio};

  logic                      f1_vld_q;
  nics_pkg::side_t           f1_side_q;
  logic [nics_pkg::MagW-1:0] f1_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (pipe_en) begin
      f1_vld_q <= dv_vld;
    end
  end

  // A slightly negative z near the midpoint flips the sign.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      f1_side_q <= '{mid: dv_side.mid, neg: dv_side.neg ^ z_w[28], last: dv_side.last};
      f1_mag_q  <= z_w[28] ? 28'(29'd0 - z_w) : z_w[27:0];
    end
  end

  logic [59:0]                prod_w;
  assign prod_w = 60'(std_q) * 60'(f1_mag_q) + 60'(1 << 23);

  logic                       f2_vld_q;
  nics_pkg::side_t            f2_side_q;
  logic [nics_pkg::ProdW-1:0] f2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_vld_q <= 1'b0;
    end else if (pipe_en) begin
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      f2_side_q <= f1_side_q;
      f2_prod_q <= prod_w[59:24];
    end
  end

  logic signed [37:0] sum_w;
  logic signed [37:0] scaled_w;
  logic signed [31:0] sat_w;

  always_comb begin
    scaled_w = f2_side_q.neg ? -$signed({2'b0, f2_prod_q}) : $signed({2'b0, f2_prod_q});
    sum_w    = 38'(mean_q) + scaled_w;
    if (sum_w > 38'sd2147483647) begin
      sat_w = 32'sh7FFFFFFF;
    end else if (sum_w < -38'sd2147483648) begin
      sat_w = 32'sh80000000;
    end else begin
      sat_w = sum_w[31:0];
    end
    if (f2_side_q.mid) begin
      sat_w = mean_q;
    end
  end

  logic            f3_vld_q;
  nics_pkg::side_t f3_side_q;
  logic [31:0]     f3_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_vld_q <= 1'b0;
    end else if (pipe_en) begin
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      f3_side_q <= f2_side_q;
      f3_res_q  <= sat_w;
    end
  end

  assign out_valid_o              = f3_vld_q;
  assign out_data_o.normal_sample = f3_res_q;
  assign out_data_o.batch_end_out = f3_side_q.last;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_mid_is_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && f3_side_q.mid |-> out_data_o.normal_sample == mean_q)
    else $error("midpoint word does not return the mean");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld |-> sq_t < 27'd117440512)
    else $error("sqrt result above 7.0");

  a_den_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pl_vld |-> pl_den >= 29'(nics_pkg::OneQ24))
    else $error("denominator below 1.0");

endmodule
